// File: hw/rtl/m3_pkg.sv
// ----------------------------------------------------------------------------
// m3_pkg
// Shared constants, types and helper functions for the 128-bit block hasher.
// ----------------------------------------------------------------------------
package m3_pkg;

  localparam logic [63:0] MUL_ONE    = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MUL_TWO    = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] ADD_ONE    = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] ADD_TWO    = 64'h0000_0000_3849_5ab5;
  localparam logic [63:0] FIN_ONE    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_TWO    = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [31:0] SEED_RESET = 32'd313;
  localparam logic [4:0]  BLOCK_BYTES = 5'd16;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // keep the low n bytes, n in 0..8
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/m3_mul64.sv
// ----------------------------------------------------------------------------
// m3_mul64
// Low 64 bits of a 64x64 product, built from one 32x32 multiplier over three
// passes: low*low, then the two cross terms folded into the upper word.
// ----------------------------------------------------------------------------
module m3_mul64 (
  input  logic             clk,
  input  logic             rst_n,
  input  m3_pkg::mul_req_t req,
  output m3_pkg::mul_rsp_t rsp
);

  typedef enum logic [1:0] {
    ST_LL,
    ST_LH,
    ST_HL
  } step_t;

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc_r;
  step_t       step_r;
  logic        busy_r;
  logic        done_r;

  logic [31:0] m_a;
  logic [31:0] m_b;
  logic [63:0] pp;

  always_comb begin
    m_a = (step_r == ST_HL) ? a_r[63:32] : a_r[31:0];
    m_b = (step_r == ST_LH) ? b_r[63:32] : b_r[31:0];
    pp  = m_a * m_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= ST_LL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        busy_r <= 1'b1;
        step_r <= ST_LL;
      end else if (busy_r) begin
        case (step_r)
          ST_LL: begin
            acc_r  <= pp;
            step_r <= ST_LH;
          end
          ST_LH: begin
            acc_r  <= acc_r + {pp[31:0], 32'h0};
            step_r <= ST_HL;
          end
          ST_HL: begin
            acc_r  <= acc_r + {pp[31:0], 32'h0};
            busy_r <= 1'b0;
            done_r <= 1'b1;
            step_r <= ST_LL;
          end
          default: begin
            busy_r <= 1'b0;
            step_r <= ST_LL;
          end
        endcase
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// File: hw/rtl/murmur3_x64_128_hash_core.sv
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash_core
// MurmurHash3 x64 128-bit message hasher, one 16-byte block per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one 16-byte block; the last one carries 0 to
// 16 valid bytes and produces the 128-bit hash on the output channel. Both
// lanes start from the seed register at the first block of every message.
// All 64-bit products go through one shared 32x32 multiplier that needs three
// passes per product. A block that is not last runs four products and four
// lane update steps. The last block runs the length fold and finalisation
// after the work of its tail: none for an empty tail, one lane's products for
// a tail of up to 8 bytes, both lanes' products for a tail of 9 to 15 bytes,
// the full block's steps for a full block, plus any time the output waits on
// out_stall. in_stall is high for the whole of that time.
// ----------------------------------------------------------------------------
module murmur3_x64_128_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_block_hi,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_lo,
  output logic [63:0] out_hash_hi
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_K1A,
    S_K1B,
    S_UPD1A,
    S_UPD1B,
    S_K2A,
    S_K2B,
    S_UPD2A,
    S_UPD2B,
    S_FIN0,
    S_FIN1,
    S_FIN2,
    S_F1A,
    S_F1B,
    S_F2A,
    S_F2B,
    S_FIN3,
    S_FIN4
  } state_t;

  state_t      state_r,     state_nxt;
  logic        pending_r,   pending_nxt;
  logic        full_r,      full_nxt;
  logic        last_r,      last_nxt;
  logic        in_msg_r,    in_msg_nxt;
  logic [63:0] w1_r,        w1_nxt;
  logic [63:0] w2_r,        w2_nxt;
  logic [63:0] h1_r,        h1_nxt;
  logic [63:0] h2_r,        h2_nxt;
  logic [63:0] x_r,         x_nxt;
  logic [31:0] len_r,       len_nxt;
  logic [31:0] seed_r,      seed_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_lo_r,    out_lo_nxt;
  logic [63:0] out_hi_r,    out_hi_nxt;

  m3_pkg::mul_req_t mul_req;
  m3_pkg::mul_rsp_t mul_rsp;

  logic [4:0]  cnt;
  logic [4:0]  cnt_m8;
  logic        full_in;
  logic [31:0] len_base;

  m3_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    cnt      = (in_valid_bytes > m3_pkg::BLOCK_BYTES) ? m3_pkg::BLOCK_BYTES : in_valid_bytes;
    cnt_m8   = cnt - 5'd8;
    full_in  = !in_last_block || (cnt == m3_pkg::BLOCK_BYTES);
    len_base = in_msg_r ? len_r : 32'd0;
  end

  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    full_nxt      = full_r;
    last_nxt      = last_r;
    in_msg_nxt    = in_msg_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    x_nxt         = x_r;
    len_nxt       = len_r;
    seed_nxt      = cfg_wr_en ? cfg_wr_data : seed_r;
    out_valid_nxt = out_valid_r;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          full_nxt   = full_in;
          last_nxt   = in_last_block;
          in_msg_nxt = !in_last_block;
          if (full_in) begin
            w1_nxt = in_block_lo;
            w2_nxt = in_block_hi;
          end else begin
            w1_nxt = in_block_lo & m3_pkg::byte_mask((cnt >= 5'd8) ? 4'd8 : cnt[3:0]);
            w2_nxt = in_block_hi & m3_pkg::byte_mask((cnt > 5'd8) ? cnt_m8[3:0] : 4'd0);
          end
          if (!in_msg_r) begin
            h1_nxt = {32'h0, seed_r};
            h2_nxt = {32'h0, seed_r};
          end
          len_nxt = len_base + (in_last_block ? {27'h0, cnt} : {27'h0, m3_pkg::BLOCK_BYTES});
          if (full_in) begin
            state_nxt = S_K1A;
          end else if (cnt > 5'd8) begin
            state_nxt = S_K2A;
          end else if (cnt != 5'd0) begin
            state_nxt = S_K1A;
          end else begin
            state_nxt = S_FIN0;
          end
        end
      end
      S_K1A: begin
        mul_req.a = w1_r;
        mul_req.b = m3_pkg::MUL_ONE;
        if (mul_rsp.done) begin
          x_nxt     = mul_rsp.prod;
          state_nxt = S_K1B;
        end
      end
      S_K1B: begin
        mul_req.a = m3_pkg::rotl64(x_r, 31);
        mul_req.b = m3_pkg::MUL_TWO;
        if (mul_rsp.done) begin
          if (full_r) begin
            x_nxt     = mul_rsp.prod;
            state_nxt = S_UPD1A;
          end else begin
            h1_nxt    = h1_r ^ mul_rsp.prod;
            state_nxt = S_FIN0;
          end
        end
      end
      S_UPD1A: begin
        h1_nxt    = m3_pkg::rotl64(h1_r ^ x_r, 27) + h2_r;
        state_nxt = S_UPD1B;
      end
      S_UPD1B: begin
        h1_nxt    = (h1_r << 2) + h1_r + m3_pkg::ADD_ONE;
        state_nxt = S_K2A;
      end
      S_K2A: begin
        mul_req.a = w2_r;
        mul_req.b = m3_pkg::MUL_TWO;
        if (mul_rsp.done) begin
          x_nxt     = mul_rsp.prod;
          state_nxt = S_K2B;
        end
      end
      S_K2B: begin
        mul_req.a = m3_pkg::rotl64(x_r, 33);
        mul_req.b = m3_pkg::MUL_ONE;
        if (mul_rsp.done) begin
          if (full_r) begin
            x_nxt     = mul_rsp.prod;
            state_nxt = S_UPD2A;
          end else begin
            h2_nxt    = h2_r ^ mul_rsp.prod;
            state_nxt = S_K1A;
          end
        end
      end
      S_UPD2A: begin
        h2_nxt    = m3_pkg::rotl64(h2_r ^ x_r, 31) + h1_r;
        state_nxt = S_UPD2B;
      end
      S_UPD2B: begin
        h2_nxt    = (h2_r << 2) + h2_r + m3_pkg::ADD_TWO;
        state_nxt = last_r ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        h1_nxt    = h1_r ^ {32'h0, len_r};
        h2_nxt    = h2_r ^ {32'h0, len_r};
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        h1_nxt    = h1_r + h2_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        h2_nxt    = h2_r + h1_r;
        state_nxt = S_F1A;
      end
      S_F1A: begin
        mul_req.a = h1_r ^ (h1_r >> 33);
        mul_req.b = m3_pkg::FIN_ONE;
        if (mul_rsp.done) begin
          x_nxt     = mul_rsp.prod;
          state_nxt = S_F1B;
        end
      end
      S_F1B: begin
        mul_req.a = x_r ^ (x_r >> 33);
        mul_req.b = m3_pkg::FIN_TWO;
        if (mul_rsp.done) begin
          h1_nxt    = mul_rsp.prod ^ (mul_rsp.prod >> 33);
          state_nxt = S_F2A;
        end
      end
      S_F2A: begin
        mul_req.a = h2_r ^ (h2_r >> 33);
        mul_req.b = m3_pkg::FIN_ONE;
        if (mul_rsp.done) begin
          x_nxt     = mul_rsp.prod;
          state_nxt = S_F2B;
        end
      end
      S_F2B: begin
        mul_req.a = x_r ^ (x_r >> 33);
        mul_req.b = m3_pkg::FIN_TWO;
        if (mul_rsp.done) begin
          h2_nxt    = mul_rsp.prod ^ (mul_rsp.prod >> 33);
          state_nxt = S_FIN3;
        end
      end
      S_FIN3: begin
        h1_nxt    = h1_r + h2_r;
        state_nxt = S_FIN4;
      end
      S_FIN4: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_lo_nxt    = h1_r;
          out_hi_nxt    = h2_r + h1_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // launch a product on entry to a multiply step, release it on completion
    if (state_r == S_K1A || state_r == S_K1B || state_r == S_K2A || state_r == S_K2B ||
        state_r == S_F1A || state_r == S_F1B || state_r == S_F2A || state_r == S_F2B) begin
      if (!pending_r) begin
        mul_req.start = 1'b1;
        pending_nxt   = 1'b1;
      end else if (mul_rsp.done) begin
        pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b0;
      in_msg_r    <= 1'b0;
      len_r       <= '0;
      seed_r      <= m3_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
      full_r      <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      in_msg_r    <= in_msg_nxt;
      len_r       <= len_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
      full_r      <= full_nxt;
      last_r      <= last_nxt;
    end
    w1_r     <= w1_nxt;
    w2_r     <= w2_nxt;
    h1_r     <= h1_nxt;
    h2_r     <= h2_nxt;
    x_r      <= x_nxt;
    out_lo_r <= out_lo_nxt;
    out_hi_r <= out_hi_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_hash_lo = out_lo_r;
  assign out_hash_hi = out_hi_r;

endmodule

// File: hw/rtl/m3_chk.sv
// ----------------------------------------------------------------------------
// m3_chk
// Port-level checks for the block hasher, bound to the top level.
// ----------------------------------------------------------------------------
module m3_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_hash_lo,
  input logic [63:0] out_hash_hi
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hash_lo) && $stable(out_hash_hi))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left a result or busy state");

endmodule

bind murmur3_x64_128_hash_core m3_chk u_m3_chk (.*);

// File: bench/murmur3_x64_128_hash_core_tb.sv
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash_core_tb
// Self-checking bench for the 128-bit block hasher.
// ----------------------------------------------------------------------------
// A queue of 16-byte blocks, grouped into messages, feeds a bursty driver.
// Every accepted block runs through a local model of the hash. Each digest
// from a finished message joins a queue of expected digests. A monitor checks
// every digest, field by field, against the oldest entry. The run starts with
// hand-picked blocks: the empty message, full and partial tails, byte counts
// above sixteen and the all-zero and all-one words. Random messages follow
// under several seeds, the zero and all-ones seeds among them, and one seed
// is written while a message is open. The receiver stalls on its own pattern
// and twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module murmur3_x64_128_hash_core_tb;

  localparam bit [63:0] C1_MUL    = 64'h87c3_7b91_1142_53d5;
  localparam bit [63:0] C2_MUL    = 64'h4cf5_ad43_2745_937f;
  localparam bit [63:0] LANE1_ADD = 64'h0000_0000_52dc_e729;
  localparam bit [63:0] LANE2_ADD = 64'h0000_0000_3849_5ab5;
  localparam bit [63:0] AVAL_M1   = 64'hff51_afd7_ed55_8ccd;
  localparam bit [63:0] AVAL_M2   = 64'hc4ce_b9fe_1a85_ec53;
  localparam bit [31:0] SEED_AT_RESET = 32'd313;
  localparam int        FULL_BLOCK    = 16;
  localparam int        NUM_SEEDS     = 6;
  localparam int        BLOCKS_PER_SEED = 330;
  localparam int        SETTLE_CYCLES = 80;
  localparam int        WATCHDOG_LIMIT = 5000;

  typedef struct {
    bit [63:0] lo;
    bit [63:0] hi;
    bit [4:0]  nbytes;
    bit        last;
  } hash_block_t;

  typedef struct {
    bit [63:0] h1;
    bit [63:0] h2;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_block_lo = '0;
  logic [63:0] in_block_hi = '0;
  logic [4:0]  in_valid_bytes = '0;
  logic        in_last_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_lo;
  logic [63:0] out_hash_hi;

  murmur3_x64_128_hash_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_block_lo    (in_block_lo),
    .in_block_hi    (in_block_hi),
    .in_valid_bytes (in_valid_bytes),
    .in_last_block  (in_last_block),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_lo    (out_hash_lo),
    .out_hash_hi    (out_hash_hi)
  );

  hash_block_t pending_blocks[$];
  digest_t     expected_digests[$];

  bit [31:0] seed_copy = SEED_AT_RESET;
  bit [63:0] hash_lane1 = '0;
  bit [63:0] hash_lane2 = '0;
  bit [31:0] msg_bytes = '0;
  bit        msg_open = 1'b0;

  int fail_count = 0;
  int blocks_accepted = 0;
  int messages_closed = 0;
  int digests_checked = 0;
  int seeds_used = 0;
  int idle_cycles = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit [63:0] rol64(input bit [63:0] v, input int unsigned n);
    bit [127:0] d;
    d = {v, v} << n;
    return d[127:64];
  endfunction

  function automatic bit [63:0] mix_k1(input bit [63:0] w);
    return rol64(w * C1_MUL, 31) * C2_MUL;
  endfunction

  function automatic bit [63:0] mix_k2(input bit [63:0] w);
    return rol64(w * C2_MUL, 33) * C1_MUL;
  endfunction

  function automatic bit [63:0] fold_avalanche(input bit [63:0] v);
    v = v ^ (v >> 33);
    v = v * AVAL_M1;
    v = v ^ (v >> 33);
    v = v * AVAL_M2;
    return v ^ (v >> 33);
  endfunction

  function automatic bit [63:0] keep_bytes(input bit [63:0] w, input int unsigned n);
    if (n >= 8) return w;
    return w & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic void lane_round(input bit [63:0] w1, input bit [63:0] w2);
    hash_lane1 = rol64(hash_lane1 ^ mix_k1(w1), 27) + hash_lane2;
    hash_lane1 = hash_lane1 * 64'd5 + LANE1_ADD;
    hash_lane2 = rol64(hash_lane2 ^ mix_k2(w2), 31) + hash_lane1;
    hash_lane2 = hash_lane2 * 64'd5 + LANE2_ADD;
  endfunction

  function automatic bit murmur_absorb(input hash_block_t b, output digest_t d);
    int unsigned n;
    bit [63:0]   a;
    bit [63:0]   c;
    d.h1 = '0;
    d.h2 = '0;
    if (!msg_open) begin
      hash_lane1 = {32'd0, seed_copy};
      hash_lane2 = {32'd0, seed_copy};
      msg_bytes  = '0;
      msg_open   = 1'b1;
    end
    n = (b.nbytes > FULL_BLOCK) ? FULL_BLOCK : b.nbytes;
    if (!b.last) begin
      lane_round(b.lo, b.hi);
      msg_bytes += FULL_BLOCK;
      return 1'b0;
    end
    if (n == FULL_BLOCK) begin
      lane_round(b.lo, b.hi);
    end else begin
      if (n > 8) hash_lane2 ^= mix_k2(keep_bytes(b.hi, n - 8));
      if (n > 0) hash_lane1 ^= mix_k1(keep_bytes(b.lo, n));
    end
    msg_bytes += n;
    a = hash_lane1 ^ {32'd0, msg_bytes};
    c = hash_lane2 ^ {32'd0, msg_bytes};
    a += c;
    c += a;
    a = fold_avalanche(a);
    c = fold_avalanche(c);
    a += c;
    c += a;
    d.h1 = a;
    d.h2 = c;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit [63:0] rand_word();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_block(input bit [63:0] lo, input bit [63:0] hi,
                                     input bit [4:0] nbytes, input bit last);
    hash_block_t b;
    b.lo = lo;
    b.hi = hi;
    b.nbytes = nbytes;
    b.last = last;
    pending_blocks.push_back(b);
  endfunction

  function automatic int queue_message();
    int len;
    int sel;
    bit [4:0] tail;
    sel = $urandom_range(0, 99);
    if (sel < 70)      len = $urandom_range(1, 4);
    else if (sel < 95) len = $urandom_range(5, 16);
    else               len = $urandom_range(17, 40);
    for (int i = 0; i < len - 1; i++)
      push_block(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0);
    sel = $urandom_range(0, 9);
    if (sel < 4)       tail = 5'd16;
    else if (sel < 9)  tail = 5'($urandom_range(0, 15));
    else               tail = 5'($urandom_range(17, 31));
    push_block(rand_word(), rand_word(), tail, 1'b1);
    return len;
  endfunction

  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_blocks.size() != 0 || in_valid || expected_digests.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input bit [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    seed_copy = v;
    seeds_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  hash_block_t cur_block;

  always @(posedge clk) begin
    digest_t d;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_fire) begin
        blocks_accepted++;
        if (murmur_absorb(cur_block, d)) begin
          expected_digests.push_back(d);
          messages_closed++;
        end
      end
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          cur_block = pending_blocks.pop_front();
          in_block_lo    <= cur_block.lo;
          in_block_hi    <= cur_block.hi;
          in_valid_bytes <= cur_block.nbytes;
          in_last_block  <= cur_block.last;
          in_valid       <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with two long hold-offs
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int holdoffs_done = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if ((holdoffs_done == 0 && digests_checked >= 30) ||
                   (holdoffs_done == 1 && digests_checked >= 200)) begin
        hold_left = $urandom_range(300, 500);
        holdoffs_done++;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= stall_tick[2];
        endcase
      end
    end
  end

  // monitor: compare every digest with the oldest expectation
  always @(posedge clk) begin
    digest_t want;
    if (rst_n && out_fire) begin
      digests_checked++;
      if (expected_digests.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected digest lo=%h hi=%h", $time, out_hash_lo, out_hash_hi);
      end else begin
        want = expected_digests.pop_front();
        if (out_hash_lo !== want.h1) begin
          fail_count++;
          $display("%0t: hash_lo mismatch expected %h actual %h", $time, want.h1,
                   out_hash_lo);
        end
        if (out_hash_hi !== want.h2) begin
          fail_count++;
          $display("%0t: hash_hi mismatch expected %h actual %h", $time, want.h2,
                   out_hash_hi);
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  bit [31:0] seed_list[NUM_SEEDS];
  int        phase_blocks;

  initial begin
    seed_list[0] = 32'h0000_0000;
    seed_list[1] = 32'hffff_ffff;
    seed_list[2] = $urandom;
    seed_list[3] = 32'h0000_0001;
    seed_list[4] = 32'h8000_0000;
    seed_list[5] = $urandom;
    wait (rst_n === 1'b1);

    push_block(rand_word(), rand_word(), 5'd0, 1'b1);
    push_block('0, '0, 5'd16, 1'b1);
    push_block('1, '1, 5'd16, 1'b1);
    push_block('1, '1, 5'd31, 1'b1);
    push_block('1, '1, 5'd17, 1'b1);
    push_block('1, '1, 5'd1, 1'b1);
    push_block('1, '1, 5'd8, 1'b1);
    push_block('1, '1, 5'd9, 1'b1);
    push_block('1, '1, 5'd15, 1'b1);
    push_block(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 5'd5, 1'b1);
    push_block('1, '1, 5'd31, 1'b0);
    push_block(rand_word(), rand_word(), 5'd7, 1'b1);
    push_block('0, '0, 5'd0, 1'b0);
    push_block(rand_word(), rand_word(), 5'd13, 1'b0);
    push_block(rand_word(), rand_word(), 5'd16, 1'b1);
    push_block('0, '0, 5'd0, 1'b0);
    push_block('0, '0, 5'd12, 1'b1);
    drain_and_settle();

    for (int p = 0; p < NUM_SEEDS; p++) begin
      write_seed(seed_list[p]);
      phase_blocks = 0;
      while (phase_blocks < BLOCKS_PER_SEED)
        phase_blocks += queue_message();
      // leave a message open so the next seed lands mid-message
      if (p == 2) begin
        push_block(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0);
        push_block(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0);
      end
      drain_and_settle();
    end

    $display("Hashed %0d blocks in %0d messages under %0d seed settings and the reset seed,",
             blocks_accepted, messages_closed, seeds_used);
    $display("with %0d digests compared and %0d long output hold-offs.", digests_checked,
             holdoffs_done);
    if (fail_count == 0 && expected_digests.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
